@@ design/jht_pkg.sv @@
// Shared types, character codes and helper functions for the JSON token scanner.
`timescale 1ns / 1ps

package jht_pkg;

    // Nesting levels that carry an object/array bit.
    localparam int unsigned MASK_LEVELS = 64;
    localparam int unsigned LVL_W       = (MASK_LEVELS > 1) ? $clog2(MASK_LEVELS) : 1;

    // Configuration port geometry: one 32-bit register per word.
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_TOKEN_LIMIT = '0;
    localparam logic [31:0] TOKEN_LIMIT_RESET = 32'hFFFF_FFFF;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        TOK_KEY    = 2'd0,
        TOK_STRING = 2'd1,
        TOK_NUMBER = 2'd2,
        TOK_CONST  = 2'd3
    } tok_type_t;

    typedef enum logic [1:0] {
        LIT_NONE  = 2'd0,
        LIT_TRUE  = 2'd1,
        LIT_FALSE = 2'd2,
        LIT_NULL  = 2'd3
    } lit_t;

    localparam byte_t CH_LBRACE  = 8'h7B;
    localparam byte_t CH_RBRACE  = 8'h7D;
    localparam byte_t CH_LBRACK  = 8'h5B;
    localparam byte_t CH_RBRACK  = 8'h5D;
    localparam byte_t CH_COMMA   = 8'h2C;
    localparam byte_t CH_COLON   = 8'h3A;
    localparam byte_t CH_QUOTE   = 8'h22;
    localparam byte_t CH_BSLASH  = 8'h5C;
    localparam byte_t CH_MINUS   = 8'h2D;
    localparam byte_t CH_PLUS    = 8'h2B;
    localparam byte_t CH_DOT     = 8'h2E;
    localparam byte_t CH_0       = 8'h30;
    localparam byte_t CH_9       = 8'h39;
    localparam byte_t CH_LOW_A   = 8'h61;
    localparam byte_t CH_LOW_Z   = 8'h7A;
    localparam byte_t CH_UP_A    = 8'h41;
    localparam byte_t CH_UP_Z    = 8'h5A;
    localparam byte_t CH_UNDER   = 8'h5F;
    localparam byte_t CH_LOW_E   = 8'h65;
    localparam byte_t CH_UP_E    = 8'h45;
    localparam byte_t CH_T       = 8'h74;
    localparam byte_t CH_F       = 8'h66;
    localparam byte_t CH_N       = 8'h6E;

    function automatic logic is_digit(byte_t b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_word_char(byte_t b);
        return is_digit(b) || ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ||
               ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_UNDER);
    endfunction

    function automatic logic [2:0] lit_len(lit_t c);
        logic [2:0] len;
        case (c)
            LIT_TRUE:  len = 3'd4;
            LIT_FALSE: len = 3'd5;
            LIT_NULL:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // Expected byte at position p of the constant's spelling.
    function automatic byte_t lit_char(lit_t c, logic [2:0] p);
        byte_t ch;
        ch = 8'h00;
        case (c)
            LIT_TRUE:
            begin
                case (p)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE:
            begin
                case (p)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL:
            begin
                case (p)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    typedef struct packed {
        word_t     token_start;
        word_t     token_length;
        tok_type_t token_type;
        word_t     token_index;
        logic      last_result;
    } tok_t;

endpackage

@@ design/jht_text_if.sv @@
// Request channel carrying one text byte and its end-of-text flag.
`timescale 1ns / 1ps

interface jht_text_if;
    import jht_pkg::*;

    logic  valid;
    logic  ready;
    byte_t text_byte;
    logic  end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ design/jht_token_if.sv @@
// Request channel carrying one reported token.
`timescale 1ns / 1ps

interface jht_token_if;
    import jht_pkg::*;

    logic      valid;
    logic      ready;
    word_t     token_start;
    word_t     token_length;
    tok_type_t token_type;
    word_t     token_index;
    logic      last_result;

    modport source (output valid, output token_start, output token_length, output token_type,
                    output token_index, output last_result, input ready);
    modport sink   (input valid, input token_start, input token_length, input token_type,
                    input token_index, input last_result, output ready);
endinterface

@@ design/json_highlight_tokenizer.sv @@
// Top level of the JSON token scanner: byte register, scan logic, token queue, APB register.
`timescale 1ns / 1ps

// JSON token scanner. While its token queue has room it takes one byte of JSON
// text per cycle on text_stream and reports object keys, strings, numbers and
// true/false/null as requests on token_stream (start offset, length, type,
// ordinal, last-of-byte flag). Throughput is one byte per clock while the queue
// has room: a byte is held in the input register until the scan logic consumes
// it and updates the mode, nesting mask and counters, and its tokens (zero, one
// or two) land in a four-entry token queue. A token passes through the input
// register and the queue before it shows on token_stream. The queue drains one
// token per clock while the sink is ready; a byte is processed only while the
// queue holds at most two tokens. With the sink always ready, a run of bytes
// that each close one token and open another sustains one byte per clock, and
// only bytes that emit two tokens (end of text with a pending token) can slow
// intake; a stalled sink holds intake once more than two tokens wait.
// The end_of_text byte flushes any pending token and restarts offsets,
// nesting and the token count at zero. The token_limit register (APB byte
// address 0, reset all ones) caps the tokens reported per document; write it
// only while the scanner is idle.
module json_highlight_tokenizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jht_pkg::PADDR_W-1:0]  paddr,
    input  jht_pkg::word_t               pwdata,
    output jht_pkg::word_t               prdata,
    output logic                         pready,
    jht_text_if.sink                     text_stream,
    jht_token_if.source                  token_stream
);
    import jht_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE = 4'd0,
        M_STR  = 4'd1,
        M_ESC  = 4'd2,
        M_INT  = 4'd3,
        M_FRAC = 4'd4,
        M_EXPS = 4'd5,
        M_EXP  = 4'd6,
        M_LIT  = 4'd7
    } mode_t;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam logic [QPTR_W:0] QROOM_FOR_TWO = (QPTR_W+1)'(QDEPTH - 2);

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    word_t limit_reg;
    logic  reg_hit;
    logic  cfg_write;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[PADDR_W-1:2] == REG_TOKEN_LIMIT);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? limit_reg : '0;

    // ---------------------------------------------------------------------
    // Input register and scan state
    // ---------------------------------------------------------------------
    logic      in_valid_reg;
    byte_t     byte_reg;
    logic      eot_reg;

    word_t                  pos_reg,     pos_next;
    word_t                  depth_reg,   depth_next;
    logic [MASK_LEVELS-1:0] mask_reg,    mask_next;
    logic                   expect_reg,  expect_next;
    mode_t                  mode_reg,    mode_next;
    word_t                  pend_reg,    pend_next;
    lit_t                   lit_reg,     lit_next;
    logic [2:0]             prog_reg,    prog_next;
    word_t                  emitted_reg, emitted_next;

    // Token queue
    tok_t              queue_mem [QDEPTH];
    logic [QPTR_W-1:0] head_reg, tail_reg;
    logic [QPTR_W:0]   count_reg;

    logic fire;
    logic accept;
    logic pop;

    assign fire   = in_valid_reg && (count_reg <= QROOM_FOR_TWO);
    assign text_stream.ready = !in_valid_reg || fire;
    assign accept = text_stream.valid && text_stream.ready;
    assign pop    = token_stream.valid && token_stream.ready;

    // ---------------------------------------------------------------------
    // Scan logic: mode step, idle step (punctuation and token starts), flush
    // ---------------------------------------------------------------------
    logic      redo;
    logic      num_end;
    logic      rep_a;
    word_t     rep_a_len;
    tok_type_t rep_a_type;
    word_t     rep_a_start;
    logic      rep_b;
    word_t     rep_b_len;
    tok_type_t rep_b_type;
    word_t     rep_b_start;
    logic      a_ok, b_ok;
    logic [32:0] b_index;
    logic [1:0]  n_tok;
    tok_t      slot0, slot1;
    logic      slot0_en, slot1_en;

    word_t             depth_inc;
    word_t             depth_dec;
    logic              push_has_bit;
    logic              cur_has_bit;
    logic [LVL_W-1:0]  push_idx;
    logic [LVL_W-1:0]  cur_idx;
    logic [2:0]        cur_len;

    always_comb
    begin
        depth_inc    = (depth_reg == 32'hFFFF_FFFF) ? depth_reg : depth_reg + 32'd1;
        depth_dec    = depth_reg - 32'd1;
        push_has_bit = (depth_inc != '0) && (depth_inc <= 32'(MASK_LEVELS));
        cur_has_bit  = (depth_reg != '0) && (depth_reg <= 32'(MASK_LEVELS));
        push_idx     = depth_reg[LVL_W-1:0];
        cur_idx      = depth_dec[LVL_W-1:0];
        cur_len      = lit_len(lit_reg);

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        lit_next    = lit_reg;
        prog_next   = prog_reg;
        expect_next = expect_reg;
        depth_next  = depth_reg;
        mask_next   = mask_reg;

        redo        = 1'b0;
        num_end     = 1'b0;
        rep_a       = 1'b0;
        rep_a_len   = '0;
        rep_a_type  = TOK_NUMBER;
        rep_a_start = pend_reg;

        // Current mode consumes the byte, or hands it back to the idle step.
        unique case (mode_reg)
            M_STR:
            begin
                if (byte_reg == CH_BSLASH)
                begin
                    mode_next = M_ESC;
                end
                else if (byte_reg == CH_QUOTE)
                begin
                    rep_a       = 1'b1;
                    rep_a_len   = pos_reg - pend_reg + 32'd1;
                    rep_a_type  = expect_reg ? TOK_KEY : TOK_STRING;
                    expect_next = 1'b0;
                    mode_next   = M_IDLE;
                    pend_next   = '0;
                    lit_next    = LIT_NONE;
                    prog_next   = '0;
                end
            end
            M_ESC:
            begin
                mode_next = M_STR;
            end
            M_INT:
            begin
                if (byte_reg == CH_DOT)
                    mode_next = M_FRAC;
                else if ((byte_reg == CH_LOW_E) || (byte_reg == CH_UP_E))
                    mode_next = M_EXPS;
                else if (!is_digit(byte_reg))
                    num_end = 1'b1;
            end
            M_FRAC:
            begin
                if ((byte_reg == CH_LOW_E) || (byte_reg == CH_UP_E))
                    mode_next = M_EXPS;
                else if (!is_digit(byte_reg))
                    num_end = 1'b1;
            end
            M_EXPS:
            begin
                if ((byte_reg == CH_PLUS) || (byte_reg == CH_MINUS) || is_digit(byte_reg))
                    mode_next = M_EXP;
                else
                    num_end = 1'b1;
            end
            M_EXP:
            begin
                if (!is_digit(byte_reg))
                    num_end = 1'b1;
            end
            M_LIT:
            begin
                if ((lit_reg != LIT_NONE) && (prog_reg < cur_len) &&
                    (byte_reg == lit_char(lit_reg, prog_reg)))
                begin
                    prog_next = prog_reg + 3'd1;
                end
                else
                begin
                    // Full spelling and a clean boundary: report the constant.
                    if ((lit_reg != LIT_NONE) && (prog_reg >= cur_len) &&
                        !is_word_char(byte_reg))
                    begin
                        rep_a      = 1'b1;
                        rep_a_len  = 32'(cur_len);
                        rep_a_type = TOK_CONST;
                    end
                    mode_next = M_IDLE;
                    pend_next = '0;
                    lit_next  = LIT_NONE;
                    prog_next = '0;
                    redo      = 1'b1;
                end
            end
            default:
            begin
                redo = 1'b1;
            end
        endcase

        // Number ended before this byte.
        if (num_end)
        begin
            rep_a      = 1'b1;
            rep_a_len  = pos_reg - pend_reg;
            rep_a_type = TOK_NUMBER;
            mode_next  = M_IDLE;
            pend_next  = '0;
            lit_next   = LIT_NONE;
            prog_next  = '0;
            redo       = 1'b1;
        end

        // Idle step: structure bytes and token starts.
        if (redo)
        begin
            case (byte_reg) inside
                CH_LBRACE:
                begin
                    depth_next = depth_inc;
                    if (push_has_bit)
                        mask_next[push_idx] = 1'b1;
                    expect_next = 1'b1;
                end
                CH_LBRACK:
                begin
                    depth_next = depth_inc;
                    if (push_has_bit)
                        mask_next[push_idx] = 1'b0;
                    expect_next = 1'b0;
                end
                CH_RBRACE, CH_RBRACK:
                begin
                    if (depth_reg != '0)
                    begin
                        if (cur_has_bit)
                            mask_next[cur_idx] = 1'b0;
                        depth_next = depth_dec;
                    end
                    if (byte_reg == CH_RBRACE)
                        expect_next = 1'b0;
                end
                CH_COMMA:
                begin
                    if (cur_has_bit && mask_reg[cur_idx])
                        expect_next = 1'b1;
                end
                CH_COLON:
                begin
                    expect_next = 1'b0;
                end
                CH_QUOTE:
                begin
                    mode_next = M_STR;
                    pend_next = pos_reg;
                end
                CH_MINUS, [CH_0:CH_9]:
                begin
                    mode_next = M_INT;
                    pend_next = pos_reg;
                end
                CH_T, CH_F, CH_N:
                begin
                    mode_next = M_LIT;
                    pend_next = pos_reg;
                    lit_next  = (byte_reg == CH_T) ? LIT_TRUE :
                                (byte_reg == CH_F) ? LIT_FALSE : LIT_NULL;
                    prog_next = 3'd1;
                end
                default:
                begin
                end
            endcase
        end

        // End-of-text flush of whatever is still pending.
        rep_b       = 1'b0;
        rep_b_len   = pos_reg - pend_next + 32'd1;
        rep_b_type  = TOK_NUMBER;
        rep_b_start = pend_next;
        if (eot_reg)
        begin
            case (mode_next) inside
                M_STR, M_ESC:
                begin
                    rep_b      = 1'b1;
                    rep_b_type = expect_next ? TOK_KEY : TOK_STRING;
                end
                M_INT, M_FRAC, M_EXPS, M_EXP:
                begin
                    rep_b      = 1'b1;
                    rep_b_type = TOK_NUMBER;
                end
                M_LIT:
                begin
                    if ((lit_next != LIT_NONE) && (prog_next == lit_len(lit_next)))
                    begin
                        rep_b      = 1'b1;
                        rep_b_len  = 32'(lit_len(lit_next));
                        rep_b_type = TOK_CONST;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Limit check and slot packing.
        a_ok     = rep_a && (emitted_reg < limit_reg);
        b_index  = {1'b0, emitted_reg} + {32'd0, a_ok};
        b_ok     = rep_b && (b_index < {1'b0, limit_reg});
        n_tok    = {1'b0, a_ok} + {1'b0, b_ok};
        slot0_en = a_ok || b_ok;
        slot1_en = a_ok && b_ok;

        slot0.token_start  = a_ok ? rep_a_start : rep_b_start;
        slot0.token_length = a_ok ? rep_a_len   : rep_b_len;
        slot0.token_type   = a_ok ? rep_a_type  : rep_b_type;
        slot0.token_index  = emitted_reg;
        slot0.last_result  = !slot1_en;

        slot1.token_start  = rep_b_start;
        slot1.token_length = rep_b_len;
        slot1.token_type   = rep_b_type;
        slot1.token_index  = b_index[31:0];
        slot1.last_result  = 1'b1;

        // End of text restarts the document.
        if (eot_reg)
        begin
            pos_next     = '0;
            depth_next   = '0;
            mask_next    = '0;
            expect_next  = 1'b0;
            emitted_next = '0;
            mode_next    = M_IDLE;
            pend_next    = '0;
            lit_next     = LIT_NONE;
            prog_next    = '0;
        end
        else
        begin
            pos_next     = pos_reg + 32'd1;
            emitted_next = emitted_reg + 32'(n_tok);
        end
    end

    // ---------------------------------------------------------------------
    // Control and state registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= TOKEN_LIMIT_RESET;
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            depth_reg    <= '0;
            mask_reg     <= '0;
            expect_reg   <= 1'b0;
            mode_reg     <= M_IDLE;
            pend_reg     <= '0;
            lit_reg      <= LIT_NONE;
            prog_reg     <= '0;
            emitted_reg  <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_write && reg_hit)
                limit_reg <= pwdata;

            if (accept)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
            begin
                pos_reg     <= pos_next;
                depth_reg   <= depth_next;
                mask_reg    <= mask_next;
                expect_reg  <= expect_next;
                mode_reg    <= mode_next;
                pend_reg    <= pend_next;
                lit_reg     <= lit_next;
                prog_reg    <= prog_next;
                emitted_reg <= emitted_next;
                tail_reg    <= tail_reg + QPTR_W'(n_tok);
            end

            if (pop)
                head_reg <= head_reg + 1'b1;

            count_reg <= count_reg + (fire ? (QPTR_W+1)'(n_tok) : '0) - (QPTR_W+1)'(pop);
        end
    end

    // Input byte payload: hold until consumed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text_stream.text_byte;
            eot_reg  <= text_stream.end_of_text;
        end
    end

    // Token queue storage: up to two writes, one read at the head.
    always_ff @(posedge clk)
    begin
        if (fire && slot0_en)
            queue_mem[tail_reg] <= slot0;
        if (fire && slot1_en)
            queue_mem[tail_reg + 1'b1] <= slot1;
    end

    assign token_stream.valid        = (count_reg != '0);
    assign token_stream.token_start  = queue_mem[head_reg].token_start;
    assign token_stream.token_length = queue_mem[head_reg].token_length;
    assign token_stream.token_type   = queue_mem[head_reg].token_type;
    assign token_stream.token_index  = queue_mem[head_reg].token_index;
    assign token_stream.last_result  = queue_mem[head_reg].last_result;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("token queue overfilled");

    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eot_reg |=> (pos_reg == '0) && (emitted_reg == '0) &&
                            (depth_reg == '0) && (mode_reg == M_IDLE))
        else $error("scan state not restarted after end of text");

    a_mask_above_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg < 32'(MASK_LEVELS)) |-> ((mask_reg >> depth_reg) == '0))
        else $error("object mask bit set above current nesting depth");

endmodule
